FILE: src/cdll_pkg.sv
// shared types and constants for the cursor doubly linked list
// no dependencies

package cdll_pkg;

    localparam int CAPACITY = 64;
    localparam int NODE_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [NODE_W-1:0] NIL_NODE = NODE_W'(CAPACITY);

    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FRONT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BACK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BACKUP  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOCUR = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_A,
        S_INS_EMPTY,
        S_INS_APP1,
        S_INS_APP2,
        S_INS_BEF1,
        S_INS_BEF2,
        S_REM_A,
        S_REM_B,
        S_REM_C,
        S_NAV_A,
        S_ADV_B,
        S_BCK_B,
        S_READ,
        S_RESP
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FRONT,
        OP_BACK,
        OP_INS_A,
        OP_INS_EMPTY,
        OP_INS_APP1,
        OP_INS_APP2,
        OP_INS_BEF1,
        OP_INS_BEF2,
        OP_LOOKUP,
        OP_REM_B,
        OP_REM_C,
        OP_ADVANCE,
        OP_BACKUP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load_value;
    } dp_cmd_t;

    typedef struct packed {
        logic free_null;
        logic cursor_null;
        logic first_null;
    } dp_flags_t;

endpackage

FILE: src/cdll_ram.sv
// generic single write port ram with registered read
// no dependencies

module cdll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/cdll_ctrl.sv
// command sequencer for the cursor doubly linked list
// depends on cdll_pkg

module cdll_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [cdll_pkg::CMD_W-1:0]     command,
    input  cdll_pkg::dp_flags_t            flags,
    output cdll_pkg::dp_cmd_t              dp_cmd,
    output logic                           busy,
    output logic                           done,
    output logic [cdll_pkg::STATUS_W-1:0]  status
);

    import cdll_pkg::*;

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= CMD_INSERT;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        status_next       = status_reg;
        dp_cmd.op         = OP_NONE;
        dp_cmd.load_value = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.load_value = 1'b1;
                    cmd_next          = command;
                    status_next       = STATUS_OK;
                    state_next        = S_READ;
                    case (command)
                        CMD_INSERT:
                        begin
                            if (flags.free_null)
                                status_next = STATUS_FULL;
                            else
                                state_next = S_INS_A;
                        end
                        CMD_REMOVE:
                        begin
                            if (flags.cursor_null)
                                status_next = STATUS_NOCUR;
                            else
                                state_next = S_REM_A;
                        end
                        CMD_FRONT:
                            dp_cmd.op = OP_FRONT;
                        CMD_BACK:
                            dp_cmd.op = OP_BACK;
                        CMD_ADVANCE, CMD_BACKUP:
                        begin
                            if (!flags.cursor_null)
                                state_next = S_NAV_A;
                        end
                        default:
                            state_next = S_READ;
                    endcase
                end
            end
            S_INS_A:
            begin
                dp_cmd.op = OP_INS_A;
                if (flags.first_null)
                    state_next = S_INS_EMPTY;
                else if (flags.cursor_null)
                    state_next = S_INS_APP1;
                else
                    state_next = S_INS_BEF1;
            end
            S_INS_EMPTY:
            begin
                dp_cmd.op  = OP_INS_EMPTY;
                state_next = S_READ;
            end
            S_INS_APP1:
            begin
                dp_cmd.op  = OP_INS_APP1;
                state_next = S_INS_APP2;
            end
            S_INS_APP2:
            begin
                dp_cmd.op  = OP_INS_APP2;
                state_next = S_READ;
            end
            S_INS_BEF1:
            begin
                dp_cmd.op  = OP_INS_BEF1;
                state_next = S_INS_BEF2;
            end
            S_INS_BEF2:
            begin
                dp_cmd.op  = OP_INS_BEF2;
                state_next = S_READ;
            end
            S_REM_A:
            begin
                dp_cmd.op  = OP_LOOKUP;
                state_next = S_REM_B;
            end
            S_REM_B:
            begin
                dp_cmd.op  = OP_REM_B;
                state_next = S_REM_C;
            end
            S_REM_C:
            begin
                dp_cmd.op  = OP_REM_C;
                state_next = S_READ;
            end
            S_NAV_A:
            begin
                dp_cmd.op = OP_LOOKUP;
                if (cmd_reg == CMD_ADVANCE)
                    state_next = S_ADV_B;
                else
                    state_next = S_BCK_B;
            end
            S_ADV_B:
            begin
                dp_cmd.op  = OP_ADVANCE;
                state_next = S_READ;
            end
            S_BCK_B:
            begin
                dp_cmd.op  = OP_BACKUP;
                state_next = S_READ;
            end
            S_READ:
                state_next = S_RESP;
            S_RESP:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_RESP);
    assign status = status_reg;

endmodule

FILE: src/cdll_datapath.sv
// node memories, list pointers and free chain of the cursor doubly linked list
// depends on cdll_pkg and cdll_ram

module cdll_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cdll_pkg::dp_cmd_t                   dp_cmd,
    input  logic signed [cdll_pkg::DATA_W-1:0]  item_value,
    output cdll_pkg::dp_flags_t                 flags,
    output logic signed [cdll_pkg::DATA_W-1:0]  cursor_value,
    output logic                                cursor_valid,
    output logic [cdll_pkg::COUNT_W-1:0]        entry_count
);

    import cdll_pkg::*;

    logic [NODE_W-1:0] first_reg, first_next;
    logic [NODE_W-1:0] last_reg, last_next;
    logic [NODE_W-1:0] cursor_reg, cursor_next;
    logic [NODE_W-1:0] free_top_reg, free_top_next;
    logic [NODE_W-1:0] fill_reg, fill_next;
    logic [NODE_W-1:0] count_reg, count_next;

    logic [DATA_W-1:0] value_reg;
    logic [NODE_W-1:0] fresh_reg;
    logic [NODE_W-1:0] gone_reg;
    logic [NODE_W-1:0] before_reg;

    logic              data_we;
    logic [ADDR_W-1:0] data_waddr;
    logic [DATA_W-1:0] data_rdata;
    logic              fwd_we;
    logic [ADDR_W-1:0] fwd_waddr;
    logic [NODE_W-1:0] fwd_wdata;
    logic [ADDR_W-1:0] fwd_raddr;
    logic [NODE_W-1:0] fwd_rdata;
    logic              bwd_we;
    logic [ADDR_W-1:0] bwd_waddr;
    logic [NODE_W-1:0] bwd_wdata;
    logic [NODE_W-1:0] bwd_rdata;

    logic              virgin;
    logic [NODE_W-1:0] free_pop;

    // untouched nodes above the fill mark chain to their successor
    assign virgin   = (free_top_reg == fill_reg);
    assign free_pop = virgin ? (fill_reg + NODE_W'(1)) : fwd_rdata;

    cdll_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (value_reg),
        .raddr (cursor_reg[ADDR_W-1:0]),
        .rdata (data_rdata)
    );

    cdll_ram #(.WIDTH(NODE_W), .DEPTH(CAPACITY)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    cdll_ram #(.WIDTH(NODE_W), .DEPTH(CAPACITY)) u_bwd_ram (
        .clk   (clk),
        .we    (bwd_we),
        .waddr (bwd_waddr),
        .wdata (bwd_wdata),
        .raddr (cursor_reg[ADDR_W-1:0]),
        .rdata (bwd_rdata)
    );

    always_comb
    begin
        first_next    = first_reg;
        last_next     = last_reg;
        cursor_next   = cursor_reg;
        free_top_next = free_top_reg;
        fill_next     = fill_reg;
        count_next    = count_reg;
        data_we       = 1'b0;
        data_waddr    = free_top_reg[ADDR_W-1:0];
        fwd_we        = 1'b0;
        fwd_waddr     = fresh_reg[ADDR_W-1:0];
        fwd_wdata     = NIL_NODE;
        fwd_raddr     = cursor_reg[ADDR_W-1:0];
        bwd_we        = 1'b0;
        bwd_waddr     = fresh_reg[ADDR_W-1:0];
        bwd_wdata     = NIL_NODE;
        case (dp_cmd.op)
            OP_FRONT:
                cursor_next = first_reg;
            OP_BACK:
                cursor_next = last_reg;
            OP_INS_A:
            begin
                data_we    = 1'b1;
                fwd_raddr  = free_top_reg[ADDR_W-1:0];
                count_next = count_reg + NODE_W'(1);
            end
            OP_INS_EMPTY:
            begin
                free_top_next = free_pop;
                fill_next     = virgin ? (fill_reg + NODE_W'(1)) : fill_reg;
                fwd_we        = 1'b1;
                bwd_we        = 1'b1;
                first_next    = fresh_reg;
                last_next     = fresh_reg;
            end
            OP_INS_APP1:
            begin
                free_top_next = free_pop;
                fill_next     = virgin ? (fill_reg + NODE_W'(1)) : fill_reg;
                fwd_we        = 1'b1;
                bwd_we        = 1'b1;
                bwd_wdata     = last_reg;
            end
            OP_INS_APP2:
            begin
                fwd_we    = 1'b1;
                fwd_waddr = last_reg[ADDR_W-1:0];
                fwd_wdata = fresh_reg;
                last_next = fresh_reg;
            end
            OP_INS_BEF1:
            begin
                free_top_next = free_pop;
                fill_next     = virgin ? (fill_reg + NODE_W'(1)) : fill_reg;
                fwd_we        = 1'b1;
                fwd_wdata     = cursor_reg;
                bwd_we        = 1'b1;
                bwd_wdata     = bwd_rdata;
            end
            OP_INS_BEF2:
            begin
                bwd_we    = 1'b1;
                bwd_waddr = cursor_reg[ADDR_W-1:0];
                bwd_wdata = fresh_reg;
                fwd_waddr = before_reg[ADDR_W-1:0];
                fwd_wdata = fresh_reg;
                if (before_reg < NIL_NODE)
                    fwd_we = 1'b1;
                else
                    first_next = fresh_reg;
            end
            OP_REM_B:
            begin
                fwd_waddr   = bwd_rdata[ADDR_W-1:0];
                fwd_wdata   = fwd_rdata;
                bwd_waddr   = fwd_rdata[ADDR_W-1:0];
                bwd_wdata   = bwd_rdata;
                cursor_next = fwd_rdata;
                count_next  = count_reg - NODE_W'(1);
                if (bwd_rdata < NIL_NODE)
                    fwd_we = 1'b1;
                else
                    first_next = fwd_rdata;
                if (fwd_rdata < NIL_NODE)
                    bwd_we = 1'b1;
                else
                    last_next = bwd_rdata;
            end
            OP_REM_C:
            begin
                fwd_we        = 1'b1;
                fwd_waddr     = gone_reg[ADDR_W-1:0];
                fwd_wdata     = free_top_reg;
                free_top_next = gone_reg;
            end
            OP_ADVANCE:
                cursor_next = fwd_rdata;
            OP_BACKUP:
                cursor_next = bwd_rdata;
            default:
                cursor_next = cursor_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg    <= NIL_NODE;
            last_reg     <= NIL_NODE;
            cursor_reg   <= NIL_NODE;
            free_top_reg <= '0;
            fill_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            first_reg    <= first_next;
            last_reg     <= last_next;
            cursor_reg   <= cursor_next;
            free_top_reg <= free_top_next;
            fill_reg     <= fill_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_value)
            value_reg <= item_value;
        if (dp_cmd.op == OP_INS_A)
            fresh_reg <= free_top_reg;
        if (dp_cmd.op == OP_LOOKUP)
            gone_reg <= cursor_reg;
        if (dp_cmd.op == OP_INS_BEF1)
            before_reg <= bwd_rdata;
    end

    assign flags.free_null   = (free_top_reg >= NIL_NODE);
    assign flags.cursor_null = (cursor_reg >= NIL_NODE);
    assign flags.first_null  = (first_reg >= NIL_NODE);

    assign cursor_valid = (cursor_reg < NIL_NODE);
    assign cursor_value = cursor_valid ? data_rdata : '0;
    assign entry_count  = COUNT_W'(count_reg);

endmodule

FILE: src/cursor_doubly_linked_list.sv
// top level of the cursor doubly linked list
// depends on cdll_pkg, cdll_ctrl and cdll_datapath
//
//  channel   handshake       payload
//  command   start / busy    command, item_value
//  result    done (strobe)   cursor_value, cursor_valid, entry_count, status
//
// one transaction at a time: to front, to back, spare codes, full insert, and advance,
// backup or remove with no cursor go straight to read and respond; the others first
// step through the dependent reads and writes of the node link rams
// the result is shown for one cycle with done; busy drops the cycle after
// no clearing pass after reset: a fill mark stands in for the initial free chain

module cursor_doubly_linked_list (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cdll_pkg::CMD_W-1:0]          command,
    input  logic signed [cdll_pkg::DATA_W-1:0]  item_value,
    output logic                                done,
    output logic signed [cdll_pkg::DATA_W-1:0]  cursor_value,
    output logic                                cursor_valid,
    output logic [cdll_pkg::COUNT_W-1:0]        entry_count,
    output logic [cdll_pkg::STATUS_W-1:0]       status
);

    import cdll_pkg::*;

    dp_cmd_t   dp_cmd;
    dp_flags_t flags;

    cdll_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .flags   (flags),
        .dp_cmd  (dp_cmd),
        .busy    (busy),
        .done    (done),
        .status  (status)
    );

    cdll_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .item_value   (item_value),
        .flags        (flags),
        .cursor_value (cursor_value),
        .cursor_valid (cursor_valid),
        .entry_count  (entry_count)
    );

endmodule
